>>> sv/ofip_pkg.sv
// ----------------------------------------------------------------------------
// ofip_pkg: shared types and constants of the face index parser
// Character codes, parser phase codes, control state and channel words.
// ----------------------------------------------------------------------------
package ofip_pkg;

   localparam int INDEX_BITS_DEFAULT = 32;
   localparam int OUT_BITS           = 32;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] PHASE_VERTEX  = 2'd0;
   localparam logic [1:0] PHASE_TEXTURE = 2'd1;
   localparam logic [1:0] PHASE_NORMAL  = 2'd2;

   localparam logic [1:0] PROG_NONE   = 2'd0;
   localparam logic [1:0] PROG_SPACE  = 2'd1;
   localparam logic [1:0] PROG_SIGN   = 2'd2;
   localparam logic [1:0] PROG_DIGITS = 2'd3;

   typedef struct packed {
      logic [1:0] phase;
      logic [1:0] progress;
      logic       negative;
      logic       halted;
   } ctl_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] vertex_index;
      logic signed [OUT_BITS-1:0] texture_index;
      logic signed [OUT_BITS-1:0] normal_index;
      logic                       group_valid;
      logic                       record_end;
   } rsp_word_type;

endpackage

>>> sv/ofip_stream_if.sv
// ----------------------------------------------------------------------------
// ofip_stream_if: valid/ready channel
// One word moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface ofip_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/ofip_step.sv
// ----------------------------------------------------------------------------
// ofip_step: next-state logic of the face index parser
// Applies one byte (and the implied NUL on the last byte) to the parser
// state; reports a finished group and the state for the next byte.
// ----------------------------------------------------------------------------
module ofip_step #(
   parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEFAULT
) (
   input  ofip_pkg::ctl_type       ctl_cur,
   input  logic [INDEX_BITS-1:0]   acc_cur,
   input  logic [INDEX_BITS-1:0]   vhold_cur,
   input  logic [INDEX_BITS-1:0]   thold_cur,
   input  logic [INDEX_BITS-1:0]   nhold_cur,
   input  logic [7:0]              char_code,
   input  logic                    last_byte,
   output ofip_pkg::ctl_type       ctl_nxt,
   output logic [INDEX_BITS-1:0]   acc_nxt,
   output logic [INDEX_BITS-1:0]   vhold_nxt,
   output logic [INDEX_BITS-1:0]   thold_nxt,
   output logic [INDEX_BITS-1:0]   nhold_nxt,
   output logic                    grp_emit,
   output logic [INDEX_BITS-1:0]   grp_v,
   output logic [INDEX_BITS-1:0]   grp_t,
   output logic [INDEX_BITS-1:0]   grp_n
);

   localparam int IB = INDEX_BITS;
   localparam int PW = INDEX_BITS + 4;
   localparam logic [IB-1:0] CAP = {1'b1, {(IB-1){1'b0}}};

   typedef struct packed {
      ofip_pkg::ctl_type ctl;
      logic [IB-1:0]     acc;
      logic [IB-1:0]     v;
      logic [IB-1:0]     t;
      logic [IB-1:0]     n;
      logic              emit;
   } work_type;

   function automatic logic is_digit(logic [7:0] c);
      return c inside {[ofip_pkg::CHAR_ZERO:ofip_pkg::CHAR_NINE]};
   endfunction

   function automatic work_type clear_number(work_type s);
      work_type r;
      r = s;
      r.ctl.progress = ofip_pkg::PROG_NONE;
      r.ctl.negative = 1'b0;
      r.acc          = '0;
      return r;
   endfunction

   // byte seen while no digits are pending
   function automatic work_type start_number(work_type s, logic [7:0] c);
      work_type r;
      logic     space;
      logic     sign;
      logic     early;
      r     = s;
      space = c inside {ofip_pkg::CHAR_SPACE, [ofip_pkg::CHAR_TAB:ofip_pkg::CHAR_CR]};
      sign  = c inside {ofip_pkg::CHAR_PLUS, ofip_pkg::CHAR_MINUS};
      early = (r.ctl.progress == ofip_pkg::PROG_NONE) ||
              (r.ctl.progress == ofip_pkg::PROG_SPACE);
      if (is_digit(c)) begin
         r.ctl.progress = ofip_pkg::PROG_DIGITS;
         r.acc          = IB'(c - ofip_pkg::CHAR_ZERO);
      end else if (early && space) begin
         r.ctl.progress = ofip_pkg::PROG_SPACE;
      end else if (early && sign) begin
         r.ctl.progress = ofip_pkg::PROG_SIGN;
         r.ctl.negative = (c == ofip_pkg::CHAR_MINUS);
      end else begin
         case (r.ctl.phase)
            ofip_pkg::PHASE_VERTEX: begin
            end
            ofip_pkg::PHASE_TEXTURE: begin
               r.t = '0;
               if (r.ctl.progress == ofip_pkg::PROG_NONE && c == ofip_pkg::CHAR_SLASH) begin
                  r           = clear_number(r);
                  r.ctl.phase = ofip_pkg::PHASE_NORMAL;
                  return r;
               end
               r.emit = 1'b1;
            end
            default: begin
               r.n    = '0;
               r.emit = 1'b1;
            end
         endcase
         r            = clear_number(r);
         r.ctl.halted = 1'b1;
      end
      return r;
   endfunction

   function automatic work_type feed(work_type s, logic [7:0] c);
      work_type      r;
      logic [PW-1:0] prod;
      logic [IB-1:0] val;
      r = s;
      if (r.ctl.halted) begin
         return r;
      end
      if (r.ctl.progress == ofip_pkg::PROG_DIGITS) begin
         if (is_digit(c)) begin
            prod  = (PW'(r.acc) << 3) + (PW'(r.acc) << 1) + PW'(c - ofip_pkg::CHAR_ZERO);
            r.acc = (prod > PW'(CAP)) ? CAP : prod[IB-1:0];
            return r;
         end
         if (r.ctl.negative) begin
            val = '0 - r.acc;
         end else begin
            val = r.acc[IB-1] ? ~CAP : r.acc;
         end
         r = clear_number(r);
         case (r.ctl.phase)
            ofip_pkg::PHASE_VERTEX: begin
               if (val == '0) begin
                  r.ctl.halted = 1'b1;
                  return r;
               end
               r.v = val;
               if (c == ofip_pkg::CHAR_SLASH) begin
                  r.ctl.phase = ofip_pkg::PHASE_TEXTURE;
                  return r;
               end
            end
            ofip_pkg::PHASE_TEXTURE: begin
               r.t = val;
               if (c == ofip_pkg::CHAR_SLASH) begin
                  r.ctl.phase = ofip_pkg::PHASE_NORMAL;
                  return r;
               end
            end
            default: begin
               r.n = val;
            end
         endcase
         r.emit      = 1'b1;
         r.ctl.phase = ofip_pkg::PHASE_VERTEX;
      end
      return start_number(r, c);
   endfunction

   work_type s0;
   work_type s1;
   work_type s2;

   always_comb begin
      s0 = '{ctl: ctl_cur, acc: acc_cur, v: vhold_cur, t: thold_cur, n: nhold_cur,
             emit: 1'b0};
      s1 = feed(s0, char_code);
      s2 = last_byte ? feed(s1, ofip_pkg::CHAR_NUL) : s1;
   end

   assign grp_emit = s2.emit;
   assign grp_v    = s2.v;
   assign grp_t    = s2.t;
   assign grp_n    = s2.n;

   // a record end restarts the parser
   assign ctl_nxt   = last_byte ? '0 : s2.ctl;
   assign acc_nxt   = last_byte ? '0 : s2.acc;
   assign vhold_nxt = last_byte ? '0 : s2.v;
   assign thold_nxt = last_byte ? '0 : s2.t;
   assign nhold_nxt = last_byte ? '0 : s2.n;

endmodule

>>> sv/obj_face_index_parser.sv
// ----------------------------------------------------------------------------
// obj_face_index_parser: face record index parser
// A result word is registered and is on rsp in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless a held result word stalls rsp; the parser state updates in the accept cycle.
// A result is produced for each finished index group and for every last byte.
// Reset (synchronous) clears the parser state and empties the output register.
// ----------------------------------------------------------------------------
module obj_face_index_parser #(
   parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   ofip_stream_if.sink   req,
   ofip_stream_if.source rsp
);

   ofip_pkg::ctl_type      ctl_ff;
   ofip_pkg::ctl_type      ctl_in;
   logic [INDEX_BITS-1:0]  acc_ff, acc_in;
   logic [INDEX_BITS-1:0]  vhold_ff, vhold_in;
   logic [INDEX_BITS-1:0]  thold_ff, thold_in;
   logic [INDEX_BITS-1:0]  nhold_ff, nhold_in;
   logic                   grp_emit;
   logic [INDEX_BITS-1:0]  grp_v, grp_t, grp_n;
   logic                   rsp_valid_ff, rsp_valid_in;
   ofip_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   ofip_pkg::req_word_type req_word;
   logic                   accept;

   assign req_word  = req.payload;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   ofip_step #(
      .INDEX_BITS (INDEX_BITS)
   ) u_step (
      .ctl_cur   (ctl_ff),
      .acc_cur   (acc_ff),
      .vhold_cur (vhold_ff),
      .thold_cur (thold_ff),
      .nhold_cur (nhold_ff),
      .char_code (req_word.char_code),
      .last_byte (req_word.last_byte),
      .ctl_nxt   (ctl_in),
      .acc_nxt   (acc_in),
      .vhold_nxt (vhold_in),
      .thold_nxt (thold_in),
      .nhold_nxt (nhold_in),
      .grp_emit  (grp_emit),
      .grp_v     (grp_v),
      .grp_t     (grp_t),
      .grp_n     (grp_n)
   );

   always_comb begin
      rsp_valid_in              = grp_emit || req_word.last_byte;
      rsp_word_in.vertex_index  = grp_emit ? ofip_pkg::OUT_BITS'(signed'(grp_v)) : '0;
      rsp_word_in.texture_index = grp_emit ? ofip_pkg::OUT_BITS'(signed'(grp_t)) : '0;
      rsp_word_in.normal_index  = grp_emit ? ofip_pkg::OUT_BITS'(signed'(grp_n)) : '0;
      rsp_word_in.group_valid   = grp_emit;
      rsp_word_in.record_end    = req_word.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= '0;
         acc_ff       <= '0;
         vhold_ff     <= '0;
         thold_ff     <= '0;
         nhold_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            ctl_ff       <= ctl_in;
            acc_ff       <= acc_in;
            vhold_ff     <= vhold_in;
            thold_ff     <= thold_in;
            nhold_ff     <= nhold_in;
            rsp_valid_ff <= rsp_valid_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_word_ff;

   // empty groups carry zero indices
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.group_valid |->
         rsp_word_ff.vertex_index == '0 && rsp_word_ff.texture_index == '0 &&
         rsp_word_ff.normal_index == '0)
      else $error("empty result word carries nonzero indices");

   // record end restarts the parser with cleared carry-over values
   assert property (@(posedge clock) disable iff (reset)
      accept && req_word.last_byte |=>
         ctl_ff == '0 && thold_ff == '0 && nhold_ff == '0)
      else $error("parser state not cleared after record end");

   // a halted record ignores bytes until its end
   assert property (@(posedge clock) disable iff (reset)
      accept && ctl_ff.halted && !req_word.last_byte |=>
         $stable(ctl_ff) && !rsp_valid_ff)
      else $error("halted parser reacted to a byte");

   // a result word appears exactly for groups and record ends
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff == $past(rsp_valid_in))
      else $error("result word presence mismatch");

endmodule
